// File: design/mfr_pkg.sv
`timescale 1ns / 1ps

package mfr_pkg;

  localparam logic       OP_CHAR = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RECV = 2'd1;
  localparam logic [1:0] MODE_WAIT = 2'd2;

  localparam logic [1:0] REG_HEAD    = 2'd0;
  localparam logic [1:0] REG_TAIL    = 2'd1;
  localparam logic [1:0] REG_HDR_LEN = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  localparam logic [8:0] MARKER_POS   = 9'd7;
  localparam logic [8:0] LENGTH_POS   = 9'd9;
  localparam logic [8:0] LENGTH_EXTRA = 9'd2;

  localparam logic [7:0] HEAD_RESET    = 8'd104;
  localparam logic [7:0] TAIL_RESET    = 8'd22;
  localparam logic [5:0] HDR_LEN_RESET = 6'd10;
  localparam logic [7:0] TIMEOUT_RESET = 8'd50;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
    logic       ninth_bit;
  } item_t;

  typedef struct packed {
    logic       store_write;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       parity_error;
    logic       frame_ready;
    logic       timeout_expired;
    logic [1:0] receiver_state;
    logic [8:0] frame_count;
  } result_t;

  typedef struct packed {
    logic [7:0] head_byte;
    logic [7:0] tail_byte;
    logic [5:0] header_length;
    logic [7:0] timeout_reload;
  } cfg_t;

endpackage

// File: design/mfr_in_reg.sv
`timescale 1ns / 1ps

module mfr_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mfr_pkg::item_t in_item,
  output logic          out_valid,
  input  logic          out_take,
  output mfr_pkg::item_t out_item
);

  logic           held;
  mfr_pkg::item_t item;

  assign in_ready  = !held || out_take;
  assign out_valid = held;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// File: design/mfr_core.sv
`timescale 1ns / 1ps

module mfr_core #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  mfr_pkg::cfg_t    cfg,
  input  logic             item_valid,
  output logic             item_take,
  input  mfr_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_ready,
  output mfr_pkg::result_t res
);

  localparam logic [8:0] DEPTH = 9'(BUFFER_DEPTH);

  logic [1:0] rx_mode, rx_mode_next;
  logic [8:0] byte_count, byte_count_next;
  logic [7:0] second_marker, second_marker_next;
  logic [7:0] length_field, length_field_next;
  logic [7:0] idle_timer, idle_timer_next;
  logic       res_held;
  mfr_pkg::result_t res_next;

  logic [7:0] timer_dec;
  logic [8:0] count_inc;
  logic [8:0] frame_len;
  logic       parity_bad;
  logic [1:0] mode_start;

  assign item_take = item_valid && (!res_held || res_ready);
  assign res_valid = res_held;

  always_comb begin
    timer_dec  = idle_timer - 8'd1;
    count_inc  = byte_count + 9'd1;
    parity_bad = ^{item.rx_byte, item.ninth_bit};
    mode_start = (rx_mode == mfr_pkg::MODE_IDLE && item.rx_byte == cfg.head_byte)
                 ? mfr_pkg::MODE_RECV : rx_mode;

    rx_mode_next       = rx_mode;
    byte_count_next    = byte_count;
    second_marker_next = second_marker;
    length_field_next  = length_field;
    idle_timer_next    = idle_timer;
    res_next           = '0;
    frame_len          = 9'(length_field_next) + 9'(cfg.header_length)
                         + mfr_pkg::LENGTH_EXTRA;

    if (item.operation == mfr_pkg::OP_TICK) begin
      idle_timer_next = timer_dec;
      if (timer_dec == 8'd0) begin
        rx_mode_next             = mfr_pkg::MODE_IDLE;
        byte_count_next          = '0;
        second_marker_next       = '0;
        length_field_next        = '0;
        res_next.timeout_expired = 1'b1;
      end
    end else begin
      idle_timer_next = cfg.timeout_reload;
      if (parity_bad) begin
        res_next.parity_error = 1'b1;
      end else begin
        rx_mode_next = mode_start;
        if (mode_start == mfr_pkg::MODE_RECV && byte_count < DEPTH) begin
          res_next.store_write = 1'b1;
          res_next.store_index = byte_count[7:0];
          res_next.store_byte  = item.rx_byte;
          if (byte_count == mfr_pkg::MARKER_POS) second_marker_next = item.rx_byte;
          if (byte_count == mfr_pkg::LENGTH_POS) length_field_next = item.rx_byte;
          byte_count_next = count_inc;
          frame_len = 9'(length_field_next) + 9'(cfg.header_length)
                      + mfr_pkg::LENGTH_EXTRA;
          if (count_inc > 9'(cfg.header_length)) begin
            if (second_marker_next != cfg.head_byte) begin
              rx_mode_next       = mfr_pkg::MODE_IDLE;
              byte_count_next    = '0;
              second_marker_next = '0;
              length_field_next  = '0;
            end else if (count_inc >= frame_len && item.rx_byte == cfg.tail_byte) begin
              rx_mode_next         = mfr_pkg::MODE_WAIT;
              res_next.frame_ready = 1'b1;
            end
          end
        end
      end
    end

    res_next.receiver_state = rx_mode_next;
    res_next.frame_count    = byte_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode       <= mfr_pkg::MODE_IDLE;
      byte_count    <= '0;
      second_marker <= '0;
      length_field  <= '0;
      idle_timer    <= mfr_pkg::TIMEOUT_RESET;
      res_held      <= 1'b0;
    end else begin
      if (item_take) begin
        rx_mode       <= rx_mode_next;
        byte_count    <= byte_count_next;
        second_marker <= second_marker_next;
        length_field  <= length_field_next;
        idle_timer    <= idle_timer_next;
        res_held      <= 1'b1;
      end else if (res_ready) begin
        res_held <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res <= res_next;
    end
  end

endmodule

// File: design/meter_frame_receiver.sv
`timescale 1ns / 1ps

// Meter frame receiver. Takes one word per cycle on s_* while m_tready is
// high: a received UART character (tuser 0, data byte plus its ninth bit,
// even parity over nine bits) or a timer tick (tuser 1), and returns exactly
// one result word per input word on m_*. Each word passes an input register
// and one stage of compare/count logic into the result register; the
// receiver state (mode, byte count, captured bytes 7 and 9, inactivity timer)
// updates in that one stage. Configuration writes should be made only while
// no word is in flight.
module meter_frame_receiver #(
  parameter int BUFFER_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // rx_byte[7:0], ninth_bit[8], zero[15:9]
  input  logic        s_tuser,   // operation[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // store_write[0], store_index[8:1], store_byte[16:9], parity_error[17],
  // frame_ready[18], timeout_expired[19], receiver_state[21:20],
  // frame_count[30:22], zero[31]
  output logic [31:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  mfr_pkg::cfg_t    cfg;
  mfr_pkg::item_t   in_item;
  mfr_pkg::item_t   held_item;
  mfr_pkg::result_t res;
  logic             held_valid;
  logic             held_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_byte      <= mfr_pkg::HEAD_RESET;
      cfg.tail_byte      <= mfr_pkg::TAIL_RESET;
      cfg.header_length  <= mfr_pkg::HDR_LEN_RESET;
      cfg.timeout_reload <= mfr_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mfr_pkg::REG_HEAD:    cfg.head_byte      <= cfg_data;
        mfr_pkg::REG_TAIL:    cfg.tail_byte      <= cfg_data;
        mfr_pkg::REG_HDR_LEN: cfg.header_length  <= cfg_data[5:0];
        mfr_pkg::REG_TIMEOUT: cfg.timeout_reload <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_item.operation = s_tuser;
  assign in_item.rx_byte   = s_tdata[7:0];
  assign in_item.ninth_bit = s_tdata[8];

  mfr_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (held_valid),
    .out_take  (held_take),
    .out_item  (held_item)
  );

  mfr_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (held_valid),
    .item_take  (held_take),
    .item       (held_item),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {1'b0, res.frame_count, res.receiver_state, res.timeout_expired,
                    res.frame_ready, res.parity_error, res.store_byte,
                    res.store_index, res.store_write};

endmodule
